// File: hw/rtl/drtw_pkg.sv
// Shared types and constants of the descent rate window trigger.
// No dependencies; every other file of the block depends on this package.
package drtw_pkg;

    localparam int HEIGHT_W   = 21;
    localparam int TIME_W     = 32;
    localparam int RATE_W     = 16;
    localparam int DIFF_W     = 16;
    localparam int QUO_W      = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    typedef logic signed [HEIGHT_W-1:0] t_height;
    typedef logic [TIME_W-1:0]          t_time;
    typedef logic [RATE_W-1:0]          t_rate;
    typedef logic [DIFF_W-1:0]          t_diff;
    typedef logic [QUO_W-1:0]           t_quo;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]      t_cfg_data;

    localparam t_cfg_idx REG_HEIGHT_MAX = 3'd0;
    localparam t_cfg_idx REG_HEIGHT_MIN = 3'd1;
    localparam t_cfg_idx REG_RATE_MAX   = 3'd2;
    localparam t_cfg_idx REG_RATE_MIN   = 3'd3;
    localparam t_cfg_idx REG_ARM_HEIGHT = 3'd4;

    localparam t_height RST_HEIGHT_MAX = 21'sd1000;
    localparam t_height RST_HEIGHT_MIN = 21'sd200;
    localparam t_rate   RST_RATE_MAX   = 16'd100;
    localparam t_rate   RST_RATE_MIN   = 16'd5;
    localparam t_height RST_ARM_HEIGHT = 21'sd1500;

    localparam t_diff DT_ZERO_SUBST = 16'd1000;

endpackage

// File: hw/rtl/drtw_in_if.sv
// Sample channel of the descent rate window trigger.
// Depends on drtw_pkg for the field types.
interface drtw_in_if;
    logic               valid;
    logic               ready;
    drtw_pkg::t_height  height_above_ground;
    drtw_pkg::t_time    time_ms;
    logic               in_flight;

    modport source(output valid, output height_above_ground, output time_ms,
                   output in_flight, input ready);
    modport sink(input valid, input height_above_ground, input time_ms,
                 input in_flight, output ready);
endinterface

// File: hw/rtl/drtw_out_if.sv
// Result channel of the descent rate window trigger.
// Depends on drtw_pkg for the field types.
interface drtw_out_if;
    logic             valid;
    logic             ready;
    logic             fire;
    logic             armed;
    drtw_pkg::t_rate  average_rate;

    modport source(output valid, output fire, output armed, output average_rate,
                   input ready);
    modport sink(input valid, input fire, input armed, input average_rate,
                 output ready);
endinterface

// File: hw/rtl/descent_rate_window_trigger_core.sv
// Descent rate window trigger. One sample is taken per beat and gives one result beat;
// the result is formed by a bit-serial divider, which works out each pair rate and then
// the final average, while the ring memory is walked one entry per step.
// A new sample is taken once the previous one has left the datapath, even while its
// result still waits on the output. The ring is cleared at reset by per-entry valid bits.
module descent_rate_window_trigger_core #(
    parameter int RING_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  drtw_pkg::t_cfg_idx  i_cfg_idx,
    input  drtw_pkg::t_cfg_data i_cfg_data,
    drtw_in_if.sink             i_in,
    drtw_out_if.source          o_out
);
    import drtw_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(RING_DEPTH - 2);
    localparam int CNT_W = $clog2(QUO_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_WRITE = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_PAIR  = 4'd3;
    localparam logic [3:0] ST_MUL   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_FIN   = 4'd7;

    t_height r_height_max;
    t_height r_height_min;
    t_rate   r_rate_max;
    t_rate   r_rate_min;
    t_height r_arm_height;

    logic [3:0]            r_state;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_cnt;
    logic [RING_DEPTH-1:0] r_valid;
    logic                  r_avg;
    logic                  r_armed;
    logic                  r_out_valid;

    t_height r_mem_h [RING_DEPTH];
    t_time   r_mem_t [RING_DEPTH];
    t_height r_rd_h;
    t_time   r_rd_t;
    logic    r_rd_v;

    t_height r_h;
    t_time   r_t;
    logic    r_fly;
    t_height r_prev_h;
    t_time   r_prev_t;
    t_diff   r_dh;
    t_diff   r_div;
    t_diff   r_rem;
    t_quo    r_quo;
    t_rate   r_sum;
    logic    r_fire_q;
    logic    r_armed_q;
    t_rate   r_rate_q;

    logic [IDX_W-1:0] n_slot;
    t_height          cur_h;
    t_time            cur_t;
    logic [HEIGHT_W:0] dh_wide;
    t_time            dt_wide;
    t_diff            n_dh;
    t_diff            dt_mag;
    t_diff            n_dt;
    logic [DIFF_W:0]  trial;
    logic [DIFF_W:0]  trial_sub;
    logic             trial_ge;
    t_rate            n_sum;
    logic             n_armed;
    logic             n_fire;
    logic             in_take;
    logic             out_take;
    logic             fin_load;

    assign in_take  = i_in.valid && i_in.ready;
    assign out_take = r_out_valid && o_out.ready;
    assign fin_load = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.fire         = r_fire_q;
    assign o_out.armed        = r_armed_q;
    assign o_out.average_rate = r_rate_q;

    always_comb begin
        n_slot = (r_slot >= SLOT_LAST) ? '0 : r_slot + 1'b1;

        cur_h = r_rd_v ? r_rd_h : '0;
        cur_t = r_rd_v ? r_rd_t : '0;

        dh_wide = {r_prev_h[HEIGHT_W-1], r_prev_h} - {cur_h[HEIGHT_W-1], cur_h};
        n_dh    = dh_wide[HEIGHT_W] ? t_diff'(-dh_wide[DIFF_W-1:0]) : dh_wide[DIFF_W-1:0];
        dt_wide = r_prev_t - cur_t;
        dt_mag  = dt_wide[TIME_W-1] ? t_diff'(-dt_wide[DIFF_W-1:0]) : dt_wide[DIFF_W-1:0];
        n_dt    = (dt_mag == '0) ? DT_ZERO_SUBST : dt_mag;

        trial     = {r_rem, r_quo[QUO_W-1]};
        trial_ge  = (trial >= {1'b0, r_div});
        trial_sub = trial - {1'b0, r_div};

        n_sum = r_sum + r_quo[RATE_W-1:0];

        n_armed = r_armed || (r_fly && (r_h > r_arm_height));
        n_fire  = n_armed && r_fly && (r_h < r_height_max) && (r_h > r_height_min)
                  && (r_quo[RATE_W-1:0] < r_rate_max) && (r_quo[RATE_W-1:0] > r_rate_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height_max <= RST_HEIGHT_MAX;
            r_height_min <= RST_HEIGHT_MIN;
            r_rate_max   <= RST_RATE_MAX;
            r_rate_min   <= RST_RATE_MIN;
            r_arm_height <= RST_ARM_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HEIGHT_MAX: r_height_max <= i_cfg_data;
                REG_HEIGHT_MIN: r_height_min <= i_cfg_data;
                REG_RATE_MAX:   r_rate_max   <= i_cfg_data[RATE_W-1:0];
                REG_RATE_MIN:   r_rate_min   <= i_cfg_data[RATE_W-1:0];
                REG_ARM_HEIGHT: r_arm_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_avg       <= 1'b0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    r_slot          <= n_slot;
                    r_valid[n_slot] <= 1'b1;
                    r_idx           <= '0;
                    r_avg           <= 1'b0;
                    r_state         <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_state <= ST_PAIR;
                end
                ST_PAIR: begin
                    if (r_idx == '0) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_LOAD;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_state <= r_avg ? ST_FIN : ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (r_idx == IDX_LAST) begin
                        r_avg   <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_LOAD;
                    end
                end
                ST_FIN: begin
                    if (fin_load) begin
                        r_armed <= n_armed;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_mem_h[n_slot] <= r_h;
            r_mem_t[n_slot] <= r_t;
        end
        r_rd_h <= r_mem_h[r_idx];
        r_rd_t <= r_mem_t[r_idx];
        r_rd_v <= r_valid[r_idx];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    r_h   <= i_in.height_above_ground;
                    r_t   <= i_in.time_ms;
                    r_fly <= i_in.in_flight;
                end
            end
            ST_WRITE: begin
                r_sum <= '0;
            end
            ST_PAIR: begin
                r_prev_h <= cur_h;
                r_prev_t <= cur_t;
                r_dh     <= n_dh;
                r_div    <= n_dt;
            end
            ST_MUL: begin
                // The scale of 1000 is formed as 1024 - 16 - 8.
                r_quo <= (t_quo'(r_dh) << 10) - (t_quo'(r_dh) << 4) - (t_quo'(r_dh) << 3);
                r_rem <= '0;
            end
            ST_DIV: begin
                r_rem <= trial_ge ? trial_sub[DIFF_W-1:0] : trial[DIFF_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], trial_ge};
            end
            ST_ACC: begin
                r_sum <= n_sum;
                if (r_idx == IDX_LAST) begin
                    r_quo <= t_quo'(n_sum);
                    r_div <= t_diff'(RING_DEPTH);
                    r_rem <= '0;
                end
            end
            ST_FIN: begin
                if (fin_load) begin
                    r_fire_q  <= n_fire;
                    r_armed_q <= n_armed;
                    r_rate_q  <= r_quo[RATE_W-1:0];
                end
            end
            default: ;
        endcase
    end

endmodule

// File: hw/rtl/drtw_checker.sv
// Port-level checks of the descent rate window trigger and the bind that attaches them.
// Depends on drtw_pkg and on the ports of descent_rate_window_trigger_core.
module drtw_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input logic            i_out_fire,
    input logic            i_out_armed,
    input drtw_pkg::t_rate i_out_rate
);
    import drtw_pkg::*;

    logic r_seen_armed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_armed <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_out_armed) begin
            r_seen_armed <= 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_fire)
        && $stable(i_out_armed) && $stable(i_out_rate))
        else $error("Result beat changed while stalled.");

    a_fire_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_fire |-> i_out_armed && (i_out_rate != '0))
        else $error("Fire without arming or with a zero rate.");

    a_arm_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_seen_armed |-> i_out_armed)
        else $error("Arming latch cleared after it was set.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("Sample taken while the previous one is in work.");

endmodule

bind descent_rate_window_trigger_core drtw_checker u_drtw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_fire  (o_out.fire),
    .i_out_armed (o_out.armed),
    .i_out_rate  (o_out.average_rate)
);

// File: sim/tb.sv
// Self-checking testbench of descent_rate_window_trigger_core.
// Drives samples and register writes, predicts each trigger result in a local model of the
// ring, rate average and arming latch, and checks every result beat; needs drtw_pkg and the interfaces.
module tb;
    import drtw_pkg::*;

    localparam int RING_DEPTH  = 8;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic  fire;
        logic  armed;
        t_rate average_rate;
    } t_trigger_result;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    t_cfg_idx  cfg_idx;
    t_cfg_data cfg_data;

    drtw_in_if  sample_if();
    drtw_out_if result_if();

    descent_rate_window_trigger_core #(
        .RING_DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (sample_if),
        .o_out     (result_if)
    );

    t_height hist_height [RING_DEPTH];
    t_time   hist_time   [RING_DEPTH];
    int      hist_slot;
    logic    arm_latch;
    t_height height_max_cfg;
    t_height height_min_cfg;
    t_rate   rate_max_cfg;
    t_rate   rate_min_cfg;
    t_height arm_height_cfg;

    t_trigger_result expected_triggers[$];
    t_time flight_clock;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    err_count;
    int    n_sent;
    int    n_checked;
    int    n_fire;
    int    quiet_cycles;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void reset_trigger_model();
        for (int i = 0; i < RING_DEPTH; i++) begin
            hist_height[i] = '0;
            hist_time[i]   = '0;
        end
        hist_slot      = 0;
        arm_latch      = 1'b0;
        height_max_cfg = RST_HEIGHT_MAX;
        height_min_cfg = RST_HEIGHT_MIN;
        rate_max_cfg   = RST_RATE_MAX;
        rate_min_cfg   = RST_RATE_MIN;
        arm_height_cfg = RST_ARM_HEIGHT;
    endfunction

    function automatic t_trigger_result predict_trigger(t_height h, t_time t, logic flying);
        t_trigger_result r;
        logic [31:0] dtw;
        int unsigned dt;
        int unsigned dh;
        int unsigned sum;
        int unsigned avg;
        int dhs;
        hist_slot = (hist_slot < RING_DEPTH - 1) ? hist_slot + 1 : 0;
        hist_height[hist_slot] = h;
        hist_time[hist_slot]   = t;
        sum = 0;
        for (int i = 0; i + 2 < RING_DEPTH; i++) begin
            dtw = hist_time[i] - hist_time[i+1];
            if (dtw[31])
                dtw = -dtw;
            dt  = 32'(dtw[15:0]);
            dhs = int'(hist_height[i]) - int'(hist_height[i+1]);
            dh  = ((dhs < 0) ? -dhs : dhs) & 32'hFFFF;
            if (dt == 0)
                dt = 32'(DT_ZERO_SUBST);
            sum = (sum + (((dh * 1000) / dt) & 32'hFFFF)) & 32'hFFFF;
        end
        avg = sum / RING_DEPTH;
        if (!arm_latch && flying && h > arm_height_cfg)
            arm_latch = 1'b1;
        r.fire = arm_latch && flying && h < height_max_cfg && h > height_min_cfg &&
                 avg < rate_max_cfg && avg > rate_min_cfg;
        r.armed        = arm_latch;
        r.average_rate = t_rate'(avg);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    task automatic send_sample(input t_height h, input t_time t, input logic flying);
        while ($urandom_range(99) < send_idle_pct) begin
            sample_if.valid <= 1'b0;
            @(posedge clk);
        end
        sample_if.valid               <= 1'b1;
        sample_if.height_above_ground <= h;
        sample_if.time_ms             <= t;
        sample_if.in_flight           <= flying;
        do
            @(posedge clk);
        while (!sample_if.ready);
        expected_triggers.push_back(predict_trigger(h, t, flying));
        n_sent++;
    endtask

    task automatic wait_results_drained();
        sample_if.valid <= 1'b0;
        while (expected_triggers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_HEIGHT_MAX: height_max_cfg = t_height'(data);
            REG_HEIGHT_MIN: height_min_cfg = t_height'(data);
            REG_RATE_MAX:   rate_max_cfg   = t_rate'(data);
            REG_RATE_MIN:   rate_min_cfg   = t_rate'(data);
            REG_ARM_HEIGHT: arm_height_cfg = t_height'(data);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic fly_descent(input int len);
        int h;
        int speed;
        int dtm;
        int step;
        logic flying;
        h     = int'(arm_height_cfg) + int'($urandom_range(1500, 1));
        speed = $urandom_range(200, 5);
        repeat (len) begin
            dtm = ($urandom_range(29) == 0) ? 0 : int'($urandom_range(250, 20));
            step = speed * dtm / 1000 + int'($urandom_range(2, 0)) - 1;
            if ($urandom_range(9) == 0)
                step = -step;
            h -= step;
            flight_clock += t_time'(dtm);
            flying = ($urandom_range(19) != 0);
            send_sample(t_height'(h), flight_clock, flying);
        end
    endtask

    task automatic test_reset_window();
        t_time t0;
        t0 = 32'h7FFF_FFFF;
        send_sample(21'sh0F_FFFF, 32'h0000_0000, 1'b0);
        send_sample(21'sh10_0000, 32'hFFFF_FFFF, 1'b1);
        send_sample(21'sd0, 32'hFFFF_FFFF, 1'b0);
        send_sample(21'sd0, t0, 1'b0);
        send_sample(RST_ARM_HEIGHT, t0 + 100, 1'b1);
        send_sample(t_height'(RST_ARM_HEIGHT + 1), t0 + 200, 1'b0);
        send_sample(t_height'(RST_ARM_HEIGHT + 1), t0 + 300, 1'b1);
        for (int k = 0; k < 13; k++)
            send_sample(t_height'(1000 - 10 * k), t0 + 400 + 100 * k, 1'b1);
        send_sample(t_height'(RST_HEIGHT_MIN + 1), t0 + 1800, 1'b1);
        send_sample(RST_HEIGHT_MIN, t0 + 1900, 1'b1);
        send_sample(21'sd500, t0 + 2000, 1'b0);
    endtask

    task automatic test_register_extremes();
        wait_results_drained();
        write_reg(REG_HEIGHT_MAX, 21'h0F_FFFF);
        write_reg(REG_HEIGHT_MIN, 21'h10_0000);
        write_reg(REG_RATE_MAX, 21'h1F_FFFF);
        write_reg(REG_RATE_MIN, 21'h1F_0000);
        write_reg(REG_ARM_HEIGHT, 21'h10_0000);
        for (int k = 0; k < 3; k++)
            send_sample(t_height'(-100 * k), 32'h0001_0000 + 30 * k, 1'b1);
        wait_results_drained();
        write_reg(REG_HEIGHT_MAX, 21'h10_0000);
        write_reg(REG_HEIGHT_MIN, 21'h0F_FFFF);
        write_reg(REG_RATE_MAX, 21'h00_0000);
        write_reg(REG_RATE_MIN, 21'h00_FFFF);
        write_reg(REG_ARM_HEIGHT, 21'h0F_FFFF);
        send_sample(21'sd700, 32'h0001_0100, 1'b1);
        send_sample(21'sd650, 32'h0001_0200, 1'b1);
        wait_results_drained();
        for (int k = int'(REG_ARM_HEIGHT) + 1; k < 2 ** CFG_IDX_W; k++)
            write_reg(t_cfg_idx'(k), t_cfg_data'($urandom));
        send_sample(21'sd600, 32'h0001_0300, 1'b1);
    endtask

    task automatic run_flight_phase(input int in_idle, input int out_stall, input int quota);
        int done;
        int len;
        wait_results_drained();
        write_reg(REG_HEIGHT_MAX, t_cfg_data'($urandom_range(3000, 600)));
        write_reg(REG_HEIGHT_MIN, t_cfg_data'($urandom_range(500, 0)));
        write_reg(REG_RATE_MAX, t_cfg_data'($urandom_range(400, 40)));
        write_reg(REG_RATE_MIN, t_cfg_data'($urandom_range(30, 0)));
        write_reg(REG_ARM_HEIGHT, t_cfg_data'($urandom_range(2500, 300)));
        send_idle_pct  = in_idle;
        recv_stall_pct = out_stall;
        done = 0;
        while (done < quota) begin
            if ($urandom_range(99) < 80) begin
                len = $urandom_range(40, 10);
                if (len > quota - done)
                    len = quota - done;
                fly_descent(len);
            end else begin
                len = $urandom_range(5, 1);
                repeat (len)
                    send_sample(t_height'($urandom), t_time'($urandom), 1'($urandom));
            end
            done += len;
        end
    endtask

    task automatic test_random_flights();
        run_flight_phase(0, 0, 160);
        run_flight_phase(59, 0, 160);
        run_flight_phase(0, 59, 160);
        run_flight_phase(22, 22, 160);
    endtask

    always @(posedge clk) begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : check_results
        t_trigger_result want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (expected_triggers.size() == 0) begin
                report_mismatch("result beat with no sample pending", 1, 0);
            end else begin
                want = expected_triggers.pop_front();
                if (result_if.fire !== want.fire)
                    report_mismatch("fire", longint'(result_if.fire), longint'(want.fire));
                if (result_if.armed !== want.armed)
                    report_mismatch("armed", longint'(result_if.armed), longint'(want.armed));
                if (result_if.average_rate !== want.average_rate)
                    report_mismatch("average_rate", longint'(result_if.average_rate),
                                    longint'(want.average_rate));
                n_checked++;
                if (want.fire)
                    n_fire++;
            end
        end
    end

    always @(posedge clk) begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        rst_n                         = 1'b0;
        cfg_we                        = 1'b0;
        cfg_idx                       = '0;
        cfg_data                      = '0;
        sample_if.valid               = 1'b0;
        sample_if.height_above_ground = '0;
        sample_if.time_ms             = '0;
        sample_if.in_flight           = 1'b0;
        send_idle_pct                 = 0;
        recv_stall_pct                = 0;
        n_sent                        = 0;
        flight_clock                  = 32'h0010_0000;
        reset_trigger_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_register_extremes();
        test_random_flights();

        wait_results_drained();
        repeat (250) @(posedge clk);
        if (expected_triggers.size() != 0)
            report_mismatch("results never delivered", 0, longint'(expected_triggers.size()));
        $display("Sent %0d samples and checked %0d trigger results, %0d of them firing.",
                 n_sent, n_checked, n_fire);
        $display("Covered reset windows, register extremes and random flights %s",
                 "under four idle mixes.");
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
